/* rtl/rvdr_pkg.sv */
// Shared types, constants and helpers for the RV32 divide/remainder pipeline.
`default_nettype none
package rvdr_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned DIV_STEPS = XLEN;
    localparam int unsigned HALF_BITS = 16;

    localparam logic [1:0] MODE_UNSIGNED = 2'd0;
    localparam logic [1:0] MODE_SIGNED   = 2'd1;
    localparam logic [1:0] MODE_ONES     = 2'd2;

    typedef struct packed {
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] quo;
        logic [XLEN-1:0] den;
        logic            neg_num;
        logic            neg_quot;
        logic            ones;
    } work_t;

    // two's complement negate, one less in ones' complement mode
    function automatic logic [XLEN-1:0] flip(input logic [XLEN-1:0] v, input logic ones);
        flip = (~v) + {{(XLEN-1){1'b0}}, ~ones};
    endfunction

endpackage
`default_nettype wire

/* rtl/rvdr_front.sv */
// Operand sign conditioning stage feeding the divide cell chain.
`default_nettype none
module rvdr_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [rvdr_pkg::XLEN-1:0]     num,
    input  wire logic [rvdr_pkg::XLEN-1:0]     den,
    input  wire logic [1:0]                    action,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output rvdr_pkg::work_t                    out_work
);

    logic            valid_reg;
    rvdr_pkg::work_t work_reg;
    rvdr_pkg::work_t work_next;
    logic            ones;
    logic            neg_num;
    logic            neg_den;
    logic [rvdr_pkg::XLEN-1:0] den_abs;

    always_comb
    begin
        ones    = (action == rvdr_pkg::MODE_ONES);
        neg_num = (action != rvdr_pkg::MODE_UNSIGNED) && num[rvdr_pkg::XLEN-1];
        neg_den = (action == rvdr_pkg::MODE_SIGNED) && den[rvdr_pkg::XLEN-1];
        den_abs = neg_den ? rvdr_pkg::flip(den, ones) : den;
        work_next.rem      = '0;
        work_next.quo      = neg_num ? rvdr_pkg::flip(num, ones) : num;
        work_next.den      = den_abs;
        work_next.neg_num  = neg_num;
        work_next.neg_quot = (neg_num != neg_den) && (den_abs != '0);
        work_next.ones     = ones;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            work_reg <= work_next;
        end
    end

    a_zero_den_no_neg: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (work_reg.den == '0) |-> !work_reg.neg_quot)
        else $error("quotient sign fix flagged for zero divisor");

endmodule
`default_nettype wire

/* rtl/rvdr_cell.sv */
// One restoring divide step: develops one quotient bit per cell.
`default_nettype none
module rvdr_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire rvdr_pkg::work_t in_work,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output rvdr_pkg::work_t      out_work
);

    logic            valid_reg;
    rvdr_pkg::work_t work_reg;
    rvdr_pkg::work_t work_next;
    logic [rvdr_pkg::XLEN+1:0] diff;
    logic [rvdr_pkg::XLEN-1:0] shifted;
    logic            ge;

    always_comb
    begin
        diff    = {1'b0, in_work.rem, in_work.quo[rvdr_pkg::XLEN-1]} - {2'b00, in_work.den};
        ge      = !diff[rvdr_pkg::XLEN+1];
        shifted = {in_work.rem[rvdr_pkg::XLEN-2:0], in_work.quo[rvdr_pkg::XLEN-1]};
        work_next     = in_work;
        work_next.rem = ge ? diff[rvdr_pkg::XLEN-1:0] : shifted;
        work_next.quo = {in_work.quo[rvdr_pkg::XLEN-2:0], ge};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            work_reg <= work_next;
        end
    end

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (work_reg.den != '0) |-> (work_reg.rem < work_reg.den))
        else $error("partial remainder not below divisor");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(work_reg))
        else $error("cell lost its word while stalled");

endmodule
`default_nettype wire

/* rtl/rvdr_back.sv */
// Result sign correction and output register.
`default_nettype none
module rvdr_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire rvdr_pkg::work_t               in_work,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [2*rvdr_pkg::XLEN-1:0]        out_data
);

    logic                          valid_reg;
    logic [2*rvdr_pkg::XLEN-1:0]   data_reg;
    logic [rvdr_pkg::XLEN-1:0]     quot;
    logic [rvdr_pkg::XLEN-1:0]     rem;

    always_comb
    begin
        quot = in_work.neg_quot ? rvdr_pkg::flip(in_work.quo, in_work.ones) : in_work.quo;
        rem  = in_work.neg_num  ? rvdr_pkg::flip(in_work.rem, in_work.ones) : in_work.rem;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= {rem, quot};
        end
    end

endmodule
`default_nettype wire

/* rtl/rv32_divide_remainder.sv */
// Pipelined RV32 divide/remainder: sign stage, 32 restoring cells, correction stage.
// Throughput: one word per cycle; every stage holds one word and stalls only on
// output backpressure, bubbles inside the chain are filled while the output waits.
// Reset: rst_n asynchronous, active low, clears all stage valid flags; no other state.
`default_nettype none
module rv32_divide_remainder (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // dividend_low[15:0], dividend_high[31:16], divisor_low[47:32],
    // divisor_high[63:48], action[65:64], zero fill[71:66]
    input  wire logic [71:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // quotient_low[15:0], quotient_high[31:16], remainder_low[47:32], remainder_high[63:48]
    output logic [63:0]       m_axis_tdata
);

    localparam int unsigned N = rvdr_pkg::DIV_STEPS;

    logic            valid [N+1];
    logic            ready [N+1];
    rvdr_pkg::work_t work  [N+1];

    rvdr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .num       (s_axis_tdata[31:0]),
        .den       (s_axis_tdata[63:32]),
        .action    (s_axis_tdata[65:64]),
        .out_valid (valid[0]),
        .out_ready (ready[0]),
        .out_work  (work[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        rvdr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[i]),
            .in_ready  (ready[i]),
            .in_work   (work[i]),
            .out_valid (valid[i+1]),
            .out_ready (ready[i+1]),
            .out_work  (work[i+1])
        );
    end

    rvdr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid[N]),
        .in_ready  (ready[N]),
        .in_work   (work[N]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule
`default_nettype wire
